// ===== hw/rtl/lpht_pkg.sv =====
package lpht_pkg;

   // field widths of the request and response
   localparam int FUNC_W   = 2;
   localparam int KEY_W    = 32;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 5;
   localparam int ST_W     = 2;

   // home slot reduction works on one key digit per cycle
   localparam int DIGIT_W  = 4;
   localparam int N_DIGITS = KEY_W / DIGIT_W;
   localparam int DIG_CW   = $clog2(N_DIGITS);

   // operation codes
   localparam logic [FUNC_W-1:0] OP_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] OP_SEARCH = 2'd1;
   localparam logic [FUNC_W-1:0] OP_REMOVE = 2'd2;

   // response status codes
   localparam logic [STATUS_W-1:0] RES_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] RES_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] RES_FULL      = 2'd2;

   // slot state codes
   localparam logic [ST_W-1:0] ST_EMPTY   = 2'd0;
   localparam logic [ST_W-1:0] ST_USED    = 2'd1;
   localparam logic [ST_W-1:0] ST_DELETED = 2'd2;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [KEY_W-1:0]  key;
      logic [DATA_W-1:0] payload;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [DATA_W-1:0]   data_out;
   } rsp_type;

   // one table entry as held in the slot memory
   typedef struct packed {
      logic [ST_W-1:0]   st;
      logic [KEY_W-1:0]  key;
      logic [DATA_W-1:0] data;
   } entry_type;

endpackage

// ===== hw/rtl/linear_probe_hash_table_core.sv =====
// Open-addressing hash table of TABLE_SIZE slots with linear probing. Each request carries an
// operation (insert, search or remove), a key and a payload, and yields exactly one response.
// All entries (state, key, payload) live in one single-port-write, registered-read memory.
// After reset the block clears the slot states in a pass over all TABLE_SIZE slots, during
// which req_stall stays high. A request then runs in order through these steps: take the
// request, reduce the key modulo TABLE_SIZE one 4-bit digit at a time, issue the first memory
// read, probe one slot per cycle over the memory read port (1 to TABLE_SIZE slots), and post
// the response. An unused operation code skips hashing and probing and answers not found. One
// request is in flight at a time; a finished response waits in the output register while the
// next request is taken. Removed slots keep a deleted mark so probe chains stay intact;
// duplicate keys are allowed.
module linear_probe_hash_table_core
   import lpht_pkg::*;
#(
   parameter int TABLE_SIZE = 31
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int IDX_W = $clog2(TABLE_SIZE);
   localparam int RW    = IDX_W + DIGIT_W;
   localparam int ENT_W = $bits(entry_type);

   localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(TABLE_SIZE - 1);
   localparam logic [RW-1:0]     N_RW     = RW'(TABLE_SIZE);
   localparam logic [DIG_CW-1:0] DIG_LAST = DIG_CW'(N_DIGITS - 1);

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_HASH  = 6'b000100,
      S_READ  = 6'b001000,
      S_PROBE = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  pos_ff, pos_in;
   logic [IDX_W-1:0]  cnt_ff, cnt_in;
   logic [DIG_CW-1:0] dig_ff, dig_in;
   logic [IDX_W-1:0]  rem_ff, rem_in;
   logic [KEY_W-1:0]  key_sh_ff, key_sh_in;
   req_type           item_ff, item_in;
   rsp_type           res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   entry_type         wr_ent;
   logic [IDX_W-1:0]  rd_addr;
   logic [ENT_W-1:0]  rd_raw;
   entry_type         ent;
   logic [IDX_W-1:0]  pos_nxt;
   logic [RW-1:0]     red;
   logic [IDX_W-1:0]  rem_step;
   logic              is_used;
   logic              is_match;

   lpht_ram #(
      .WIDTH (ENT_W),
      .DEPTH (TABLE_SIZE)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_ent),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign ent      = entry_type'(rd_raw);
   assign is_used  = (ent.st == ST_USED);
   assign is_match = is_used && (ent.key == item_ff.key);
   assign pos_nxt  = (pos_ff == IDX_LAST) ? '0 : pos_ff + 1'b1;

   // remainder step: shift in the next key digit, then reduce below TABLE_SIZE
   always_comb begin
      red = {rem_ff, key_sh_ff[KEY_W-1 -: DIGIT_W]};
      for (int k = DIGIT_W - 1; k >= 0; k--) begin
         if (red >= (N_RW << k)) begin
            red = red - (N_RW << k);
         end
      end
      rem_step = red[IDX_W-1:0];
   end

   // sequencer: clear, hash, probe, write back, post response
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      cnt_in       = cnt_ff;
      dig_in       = dig_ff;
      rem_in       = rem_ff;
      key_sh_in    = key_sh_ff;
      item_in      = item_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = pos_ff;
      wr_ent       = '0;
      rd_addr      = pos_ff;

      case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            if (pos_ff == IDX_LAST) begin
               pos_in   = '0;
               state_in = S_IDLE;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end

         S_IDLE: begin
            if (req_valid) begin
               item_in         = req_data;
               key_sh_in       = req_data.key;
               rem_in          = '0;
               dig_in          = '0;
               res_in.status   = RES_NOT_FOUND;
               res_in.slot     = '0;
               res_in.data_out = '0;
               if (req_data.func == OP_INSERT || req_data.func == OP_SEARCH ||
                   req_data.func == OP_REMOVE) begin
                  state_in = S_HASH;
               end else begin
                  state_in = S_DONE;
               end
            end
         end

         S_HASH: begin
            rem_in    = rem_step;
            key_sh_in = key_sh_ff << DIGIT_W;
            dig_in    = dig_ff + 1'b1;
            if (dig_ff == DIG_LAST) begin
               state_in = S_READ;
            end
         end

         S_READ: begin
            rd_addr  = rem_ff;
            pos_in   = rem_ff;
            cnt_in   = '0;
            state_in = S_PROBE;
         end

         S_PROBE: begin
            // read of the following slot goes out every cycle; used only if probing goes on
            rd_addr = pos_nxt;
            if (item_ff.func == OP_INSERT) begin
               if (!is_used) begin
                  wr_en         = 1'b1;
                  wr_ent.st     = ST_USED;
                  wr_ent.key    = item_ff.key;
                  wr_ent.data   = item_ff.payload;
                  res_in.status = RES_OK;
                  res_in.slot   = SLOT_W'(pos_ff);
                  state_in      = S_DONE;
               end else if (cnt_ff == IDX_LAST) begin
                  res_in.status = RES_FULL;
                  state_in      = S_DONE;
               end else begin
                  pos_in = pos_nxt;
                  cnt_in = cnt_ff + 1'b1;
               end
            end else begin
               if (ent.st == ST_EMPTY) begin
                  state_in = S_DONE;
               end else if (is_match) begin
                  if (item_ff.func == OP_REMOVE) begin
                     wr_en       = 1'b1;
                     wr_ent.st   = ST_DELETED;
                     wr_ent.key  = ent.key;
                     wr_ent.data = ent.data;
                  end else begin
                     res_in.data_out = ent.data;
                  end
                  res_in.status = RES_OK;
                  res_in.slot   = SLOT_W'(pos_ff);
                  state_in      = S_DONE;
               end else if (cnt_ff == IDX_LAST) begin
                  state_in = S_DONE;
               end else begin
                  pos_in = pos_nxt;
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         pos_ff       <= '0;
         cnt_ff       <= '0;
         dig_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         cnt_ff       <= cnt_in;
         dig_ff       <= dig_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      key_sh_ff <= key_sh_in;
      item_ff   <= item_in;
      res_ff    <= res_in;
      rsp_ff    <= rsp_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== hw/rtl/lpht_ram.sv =====
module lpht_ram
   import lpht_pkg::*;
#(
   parameter int WIDTH = 66,
   parameter int DEPTH = 31
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== tb/tb_linear_probe_hash_table_core.sv =====
`timescale 1ns / 100ps

module tb_linear_probe_hash_table_core;
   import lpht_pkg::*;

   localparam int unsigned SLOTS = 31;
   localparam int NUM_DIR = 23;
   localparam int RANDOM_ITEMS = 1600;
   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int HOLD_AT = 300;
   localparam int HOLD_CYCLES = 500;
   localparam int DRAIN_CYCLES = 60;

   // code the block answers as not found without touching the slots
   localparam logic [FUNC_W-1:0] OP_UNUSED = 2'd3;

   localparam rsp_type MISS = {RES_NOT_FOUND, 5'd0, 32'h0000_0000};
   localparam rsp_type UNTYPED = {RES_OK, 5'd0, 32'h0000_0000};

   typedef struct packed {
      req_type req;
      logic    typed;
      rsp_type rsp;
   } dir_row_type;

   typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // shadow copy of the slot memory
   logic [KEY_W-1:0]  mirror_key [SLOTS];
   logic [DATA_W-1:0] mirror_data [SLOTS];
   logic [ST_W-1:0]   mirror_st [SLOTS];

   rsp_type     awaited_rsps [$];
   rsp_type     want_rsp;
   dir_row_type dir_rows [NUM_DIR];
   int          mismatches = 0;
   int          items_sent = 0;
   int unsigned cycle_count = 0;
   bit          quiet = 1'b0;

   linear_probe_hash_table_core #(
      .TABLE_SIZE(SLOTS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // probe the shadow table and apply one operation to it
   function automatic rsp_type apply_table_op(req_type r);
      rsp_type     res;
      int unsigned pos;
      int          hit;
      res = '0;
      res.status = RES_NOT_FOUND;
      hit = -1;
      pos = r.key % SLOTS;
      if (r.func == OP_INSERT || r.func == OP_SEARCH || r.func == OP_REMOVE) begin
         for (int n = 0; n < SLOTS; n++) begin
            if (r.func == OP_INSERT) begin
               if (mirror_st[pos] != ST_USED) begin
                  hit = pos;
                  break;
               end
            end else begin
               if (mirror_st[pos] == ST_EMPTY) break;
               if (mirror_st[pos] == ST_USED && mirror_key[pos] == r.key) begin
                  hit = pos;
                  break;
               end
            end
            pos = (pos == SLOTS - 1) ? 0 : pos + 1;
         end
      end
      if (r.func == OP_INSERT) begin
         if (hit < 0) begin
            res.status = RES_FULL;
         end else begin
            mirror_key[hit] = r.key;
            mirror_data[hit] = r.payload;
            mirror_st[hit] = ST_USED;
            res.status = RES_OK;
            res.slot = hit[SLOT_W-1:0];
         end
      end else if (r.func == OP_SEARCH && hit >= 0) begin
         res.status = RES_OK;
         res.slot = hit[SLOT_W-1:0];
         res.data_out = mirror_data[hit];
      end else if (r.func == OP_REMOVE && hit >= 0) begin
         mirror_st[hit] = ST_DELETED;
         res.status = RES_OK;
         res.slot = hit[SLOT_W-1:0];
      end
      return res;
   endfunction

   // key of some occupied slot, random when the table holds none
   function automatic logic [KEY_W-1:0] pick_stored_key();
      int unsigned start;
      start = $urandom_range(0, SLOTS - 1);
      for (int n = 0; n < SLOTS; n++) begin
         if (mirror_st[(start + n) % SLOTS] == ST_USED) return mirror_key[(start + n) % SLOTS];
      end
      return $urandom();
   endfunction

   // new key, mostly homed near a cluster center so that chains form
   function automatic logic [KEY_W-1:0] fresh_key(int unsigned center);
      logic [KEY_W-1:0] k;
      k = $urandom();
      if ($urandom_range(0, 3) != 0) k = k - (k % SLOTS) + center + $urandom_range(0, 5);
      return k;
   endfunction

   // idle length, mostly short with a few long ones
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 50) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // offer one request, predict its response once the transfer happens
   task automatic send_item(req_type item, logic typed, rsp_type typed_rsp);
      int      gap;
      rsp_type predicted;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      predicted = apply_table_op(item);
      awaited_rsps.push_back(typed ? typed_rsp : predicted);
      items_sent++;
   endtask

   // response side back-pressure, with one long hold-off to fill the block
   initial begin
      int  run_left;
      bit  run_level;
      int  hold_left;
      bit  held_once;
      int  roll;
      run_left = 0;
      run_level = 1'b0;
      hold_left = 0;
      held_once = 1'b0;
      forever begin
         @(negedge clock);
         if (!held_once && items_sent >= HOLD_AT) begin
            held_once = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (quiet) begin
            rsp_stall <= 1'b0;
         end else begin
            if (run_left == 0) begin
               roll = $urandom_range(0, 99);
               run_level = ($urandom_range(0, 99) < 35);
               if (roll < 85) run_left = $urandom_range(1, 3);
               else if (roll < 97) run_left = $urandom_range(4, 12);
               else run_left = $urandom_range(20, 80);
            end else begin
               run_left--;
            end
            rsp_stall <= run_level;
         end
      end
   end

   // compare each response transfer with the oldest prediction
   always @(posedge clock) begin
      if (!reset && $isunknown(rsp_valid)) begin
         $display("%0t: rsp_valid expected 0/1 actual %b", $time, rsp_valid);
         mismatches++;
      end
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (awaited_rsps.size() == 0) begin
            $display("%0t: response expected none actual %p", $time, rsp_data);
            mismatches++;
         end else begin
            want_rsp = awaited_rsps.pop_front();
            if (rsp_data.status !== want_rsp.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, want_rsp.status, rsp_data.status);
               mismatches++;
            end
            if (rsp_data.slot !== want_rsp.slot) begin
               $display("%0t: slot expected %0d actual %0d",
                        $time, want_rsp.slot, rsp_data.slot);
               mismatches++;
            end
            if (rsp_data.data_out !== want_rsp.data_out) begin
               $display("%0t: data_out expected %h actual %h",
                        $time, want_rsp.data_out, rsp_data.data_out);
               mismatches++;
            end
         end
      end
   end

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[linear_probe_hash_table_core] ERROR");
      $finish;
   end

   initial begin
      req_type     item;
      mix_type     mix;
      int          real_items;
      int          episode;
      int          episode_len;
      int unsigned center;
      int          roll;
      int          ins_w;
      int          srch_w;
      real_items = 0;
      episode = 0;
      foreach (mirror_st[i]) mirror_st[i] = ST_EMPTY;

      // directed rows: empty table, extremes, collisions, deleted marks, wraparound
      dir_rows = '{
         {OP_SEARCH, 32'h0000_0000, 32'h0000_0000, 1'b1, MISS},
         {OP_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, MISS},
         {OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, MISS},
         {OP_INSERT, 32'h0000_0000, 32'h0000_0000, 1'b1, {RES_OK, 5'd0, 32'h0000_0000}},
         {OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, {RES_OK, 5'd3, 32'h0000_0000}},
         {OP_SEARCH, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, {RES_OK, 5'd3, 32'hFFFF_FFFF}},
         {OP_SEARCH, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, {RES_OK, 5'd0, 32'h0000_0000}},
         {OP_INSERT, 32'd31, 32'hA5A5_A5A5, 1'b0, UNTYPED},
         {OP_INSERT, 32'd62, 32'h5A5A_5A5A, 1'b0, UNTYPED},
         {OP_INSERT, 32'd0, 32'h1234_5678, 1'b0, UNTYPED},
         {OP_REMOVE, 32'd31, 32'hFFFF_FFFF, 1'b0, UNTYPED},
         {OP_SEARCH, 32'd62, 32'h0000_0000, 1'b0, UNTYPED},
         {OP_SEARCH, 32'd31, 32'h0000_0000, 1'b0, UNTYPED},
         {OP_INSERT, 32'd93, 32'hDEAD_BEEF, 1'b0, UNTYPED},
         {OP_SEARCH, 32'd0, 32'h0000_0000, 1'b0, UNTYPED},
         {OP_REMOVE, 32'd0, 32'h0000_0000, 1'b0, UNTYPED},
         {OP_SEARCH, 32'd0, 32'h0000_0000, 1'b0, UNTYPED},
         {OP_UNUSED, 32'd0, 32'h0000_0000, 1'b1, MISS},
         {OP_REMOVE, 32'd30, 32'h0000_0000, 1'b1, MISS},
         {OP_INSERT, 32'd30, 32'h0F0F_0F0F, 1'b0, UNTYPED},
         {OP_INSERT, 32'd61, 32'hF0F0_F0F0, 1'b0, UNTYPED},
         {OP_SEARCH, 32'd61, 32'h0000_0000, 1'b0, UNTYPED},
         {OP_INSERT, 32'hFFFF_FFFE, 32'h8000_0001, 1'b0, UNTYPED}
      };

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) send_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);

      // random episodes: fill toward full, drain with removes, or balanced traffic
      while (real_items < RANDOM_ITEMS) begin
         mix = (episode < 2) ? MIX_BALANCED : mix_type'($urandom_range(0, 2));
         quiet = ($urandom_range(0, 4) == 0);
         episode_len = $urandom_range(30, 120);
         center = $urandom_range(0, SLOTS - 1);
         case (mix)
            MIX_FILL: begin
               ins_w = 70;
               srch_w = 15;
            end
            MIX_DRAIN: begin
               ins_w = 15;
               srch_w = 25;
            end
            default: begin
               ins_w = 35;
               srch_w = 35;
            end
         endcase
         repeat (episode_len) begin
            roll = $urandom_range(0, 99);
            item.payload = $urandom();
            if (roll < 4) begin
               item.func = OP_UNUSED;
               item.key = $urandom();
            end else if (roll < 4 + ins_w) begin
               item.func = OP_INSERT;
               item.key = ($urandom_range(0, 3) == 0) ? pick_stored_key() : fresh_key(center);
            end else if (roll < 4 + ins_w + srch_w) begin
               item.func = OP_SEARCH;
               item.key = ($urandom_range(0, 3) != 0) ? pick_stored_key() : fresh_key(center);
            end else begin
               item.func = OP_REMOVE;
               item.key = ($urandom_range(0, 4) != 0) ? pick_stored_key() : fresh_key(center);
            end
            send_item(item, 1'b0, UNTYPED);
            if (item.func != OP_UNUSED) real_items++;
         end
         episode++;
      end

      // stop offering once the last transfer is done
      @(negedge clock);
      req_valid <= 1'b0;

      // drain outstanding responses, then watch for strays
      while (awaited_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("[linear_probe_hash_table_core] OK");
      end else begin
         $display("[linear_probe_hash_table_core] ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/lpht_pkg.sv
hw/rtl/lpht_ram.sv
hw/rtl/linear_probe_hash_table_core.sv
tb/tb_linear_probe_hash_table_core.sv
